// ----- src/krs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package krs_pkg;

    localparam logic [63:0] POS_ZERO = 64'h0000_0000_0000_0000;
    localparam logic [63:0] DEFAULT_NAN = 64'hFFF8_0000_0000_0000;
    localparam logic [10:0] EXP_MAX = 11'h7FF;

    function automatic logic is_nan(input logic [63:0] a);
        return (a[62:52] == EXP_MAX) && (a[51:0] != 52'd0);
    endfunction

    function automatic logic is_inf(input logic [63:0] a);
        return (a[62:52] == EXP_MAX) && (a[51:0] == 52'd0);
    endfunction

    // round-to-nearest-even double add, nan rules of common hardware
    function automatic logic [63:0] fadd(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] x;
        logic [63:0] y;
        logic        sx;
        logic        sy;
        logic [11:0] ex;
        logic [11:0] ey;
        logic [11:0] diff;
        logic [55:0] mx;
        logic [55:0] my;
        logic [55:0] sh;
        logic        stk;
        logic [56:0] sum;
        logic [11:0] e;
        logic [5:0]  lz;
        logic        found;
        logic [11:0] shamt;
        logic [52:0] man;
        logic [53:0] rnd;
        logic        up;
        logic [63:0] res;
        res = POS_ZERO;
        if (is_nan(a))
        begin
            res = a | 64'h0008_0000_0000_0000;
        end
        else if (is_nan(b))
        begin
            res = b | 64'h0008_0000_0000_0000;
        end
        else if (is_inf(a) && is_inf(b) && (a[63] != b[63]))
        begin
            res = DEFAULT_NAN;
        end
        else if (is_inf(a))
        begin
            res = a;
        end
        else if (is_inf(b))
        begin
            res = b;
        end
        else
        begin
            if (a[62:0] >= b[62:0])
            begin
                x = a;
                y = b;
            end
            else
            begin
                x = b;
                y = a;
            end
            sx = x[63];
            sy = y[63];
            ex = (x[62:52] == 11'd0) ? 12'd1 : {1'b0, x[62:52]};
            ey = (y[62:52] == 11'd0) ? 12'd1 : {1'b0, y[62:52]};
            mx = {(x[62:52] != 11'd0), x[51:0], 3'b000};
            my = {(y[62:52] != 11'd0), y[51:0], 3'b000};
            diff = ex - ey;
            if (diff >= 12'd56)
            begin
                sh = 56'd0;
                stk = |my;
            end
            else
            begin
                sh = my >> diff[5:0];
                stk = |(my & ((56'd1 << diff[5:0]) - 56'd1));
            end
            sh[0] = sh[0] | stk;
            e = ex;
            if (sx == sy)
            begin
                sum = {1'b0, mx} + {1'b0, sh};
            end
            else
            begin
                sum = {1'b0, mx} - {1'b0, sh};
            end
            if (sum == 57'd0)
            begin
                // exact cancellation gives +0, like-signed zeros keep sign
                res = {(sx == sy) ? sx : 1'b0, 63'd0};
            end
            else
            begin
                if (sum[56])
                begin
                    sum = {1'b0, sum[56:2], sum[1] | sum[0]};
                    e = e + 12'd1;
                end
                else
                begin
                    lz = 6'd0;
                    found = 1'b0;
                    for (int i = 55; i >= 0; i--)
                    begin
                        if (!found && sum[i])
                        begin
                            found = 1'b1;
                            lz = 6'(55 - i);
                        end
                    end
                    shamt = ({6'd0, lz} > (e - 12'd1)) ? (e - 12'd1) : {6'd0, lz};
                    sum = sum << shamt[5:0];
                    e = e - shamt;
                end
                man = sum[55:3];
                up = sum[2] && (sum[1] || sum[0] || man[0]);
                rnd = {1'b0, man} + {53'd0, up};
                if (rnd[53])
                begin
                    rnd = {1'b0, rnd[53:1]};
                    e = e + 12'd1;
                end
                if (e >= 12'd2047)
                begin
                    res = {sx, EXP_MAX, 52'd0};
                end
                else
                begin
                    res = {sx, rnd[52] ? e[10:0] : 11'd0, rnd[51:0]};
                end
            end
        end
        return res;
    endfunction

    function automatic logic [63:0] fsub(input logic [63:0] a, input logic [63:0] b);
        return fadd(a, is_nan(b) ? b : {~b[63], b[62:0]});
    endfunction

endpackage
`default_nettype wire

// ----- src/kahan_running_sum_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// channel | signals                                      | word
// in      | in_valid in_ready value_bits first_of_list   | one double plus list-start flag
// out     | out_valid out_ready running_sum_bits         | compensated running total
//
// one word per cycle sustained while out_ready holds; each word is registered in the input
// register and then sits in the result register
// the four chained double adds on total and compensation set the clock
// reset clears both registers' valid flags and sets total and compensation to +0
// a stalled result holds; the input register still fills behind it
module kahan_running_sum_core
    import krs_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [63:0]   value_bits,
    input  wire logic          first_of_list,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [63:0]        running_sum_bits
);

    logic        s_valid_reg;
    logic [63:0] s_value_reg;
    logic        s_first_reg;
    logic        out_valid_reg;
    logic [63:0] out_data_reg;
    logic [63:0] total_reg;
    logic [63:0] total_next;
    logic [63:0] comp_reg;
    logic [63:0] comp_next;
    logic        advance;
    logic [63:0] tot_in;
    logic [63:0] comp_in;
    logic [63:0] y_val;
    logic [63:0] d_val;

    // result register free, or being drained this cycle
    assign advance  = s_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s_valid_reg || advance;

    // kahan step: y = x - c, t = s + y, c = (t - s) - y
    always_comb
    begin
        tot_in     = s_first_reg ? POS_ZERO : total_reg;
        comp_in    = s_first_reg ? POS_ZERO : comp_reg;
        y_val      = fsub(s_value_reg, comp_in);
        total_next = fadd(tot_in, y_val);
        d_val      = fsub(total_next, tot_in);
        comp_next  = fsub(d_val, y_val);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            total_reg     <= POS_ZERO;
            comp_reg      <= POS_ZERO;
        end
        else
        begin
            if (in_ready)
            begin
                s_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                total_reg     <= total_next;
                comp_reg      <= comp_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s_value_reg <= value_bits;
            s_first_reg <= first_of_list;
        end
        if (advance)
        begin
            out_data_reg <= total_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign running_sum_bits = out_data_reg;

    // a loaded word that cannot move keeps the input side closed
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (s_valid_reg && out_valid_reg && !out_ready) |-> !in_ready)
        else $error("input accepted while both stages are full");

    // every advance makes a result available next cycle
    a_adv_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid)
        else $error("advanced word produced no result");

    // state changes only when a word is summed
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(total_reg) && $stable(comp_reg))
        else $error("running sum changed without a word");

endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
    import krs_pkg::*;

    localparam logic [63:0] NEG_ZERO = 64'h8000_0000_0000_0000;
    localparam logic [63:0] PLUS_INF = 64'h7FF0_0000_0000_0000;
    localparam logic [63:0] MINUS_INF = 64'hFFF0_0000_0000_0000;
    localparam logic [63:0] QUIET_BIT = 64'h0008_0000_0000_0000;
    localparam logic [63:0] GEN_NAN = 64'hFFF8_0000_0000_0000;
    localparam logic [63:0] MAX_FINITE = 64'h7FEF_FFFF_FFFF_FFFF;
    localparam logic [63:0] MIN_SUBNORM = 64'h0000_0000_0000_0001;
    localparam logic [63:0] ONE = 64'h3FF0_0000_0000_0000;
    localparam logic [63:0] BIG_2P53 = 64'h4340_0000_0000_0000;

    typedef struct packed {
        logic [63:0] value;
        logic        first;
    } word_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [63:0] value_bits;
    logic        first_of_list;
    logic        out_valid;
    logic        out_ready;
    logic [63:0] running_sum_bits;

    word_t       pending_words[$];
    logic [63:0] sum_expected[$];
    logic [63:0] acc_total;
    logic [63:0] acc_comp;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_left;
    int          n_words;
    int          n_sums;
    int          n_lists;
    int          n_errors;

    kahan_running_sum_core u_top (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .value_bits(value_bits),
        .first_of_list(first_of_list),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .running_sum_bits(running_sum_bits)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    function automatic logic dbl_is_nan(input logic [63:0] a);
        return (a[62:52] == 11'h7FF) && (a[51:0] != 52'd0);
    endfunction

    // ieee add through native reals, nan selection done explicitly
    function automatic logic [63:0] dbl_add(input logic [63:0] a, input logic [63:0] b);
        if (dbl_is_nan(a))
            return a | QUIET_BIT;
        if (dbl_is_nan(b))
            return b | QUIET_BIT;
        if ((a[62:0] == PLUS_INF[62:0]) && (b[62:0] == PLUS_INF[62:0]) && (a[63] != b[63]))
            return GEN_NAN;
        return $realtobits($bitstoreal(a) + $bitstoreal(b));
    endfunction

    function automatic logic [63:0] dbl_sub(input logic [63:0] a, input logic [63:0] b);
        return dbl_add(a, dbl_is_nan(b) ? b : {~b[63], b[62:0]});
    endfunction

    // one kahan step on the predicted state
    task automatic kahan_advance(input logic [63:0] x, input logic first);
        logic [63:0] y;
        logic [63:0] t;
        if (first)
        begin
            acc_total = POS_ZERO;
            acc_comp = POS_ZERO;
        end
        y = dbl_sub(x, acc_comp);
        t = dbl_add(acc_total, y);
        acc_comp = dbl_sub(dbl_sub(t, acc_total), y);
        acc_total = t;
        sum_expected.push_back(t);
    endtask

    function automatic logic [63:0] rand_double(input int base_exp);
        logic [63:0] r;
        int          pick;
        pick = $urandom_range(0, 99);
        r = {$urandom, $urandom};
        if (pick < 60)
            r[62:52] = 11'(base_exp + $urandom_range(0, 8) - 4);
        else if (pick < 70)
            r[62:52] = 11'd0;
        else if (pick < 74)
        begin
            r[62:52] = 11'h7FF;
            if ($urandom_range(0, 1) == 0)
                r[51:0] = 52'd0;
        end
        else if (pick < 78)
            r[62:0] = 63'd0;
        return r;
    endfunction

    task automatic push_word(input logic [63:0] v, input logic f);
        word_t w;
        w.value = v;
        w.first = f;
        pending_words.push_back(w);
    endtask

    // lists with random length and a common magnitude, some noise words
    task automatic push_random(input int count);
        int k;
        int len;
        int base_exp;
        k = 0;
        while (k < count)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                push_word({$urandom, $urandom}, 1'($urandom));
                k++;
            end
            else
            begin
                len = $urandom_range(1, 40);
                base_exp = $urandom_range(4, 2042);
                if ($urandom_range(0, 3) == 0)
                    base_exp = $urandom_range(1000, 1060);
                for (int i = 0; i < len && k < count; i++)
                begin
                    push_word(rand_double(base_exp), i == 0);
                    k++;
                end
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_words.size() != 0 || in_valid || sum_expected.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // input side: a word leaves the queue once the previous one is taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            value_bits <= 64'd0;
            first_of_list <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                kahan_advance(value_bits, first_of_list);
                n_words++;
                if (first_of_list)
                    n_lists++;
            end
            if (!in_valid || in_ready)
            begin
                if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    value_bits <= pending_words[0].value;
                    first_of_list <= pending_words[0].first;
                    void'(pending_words.pop_front());
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // long hold-off counter, one step per cycle
    always @(posedge clk)
    begin
        if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // output side: random stalls plus an optional long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (sum_expected.size() == 0)
                begin
                    $display("%0t: unexpected sum %h", $time, running_sum_bits);
                    n_errors++;
                end
                else
                begin
                    if (running_sum_bits !== sum_expected[0])
                    begin
                        $display("%0t: running_sum_bits expected %h actual %h",
                                 $time, sum_expected[0], running_sum_bits);
                        n_errors++;
                    end
                    void'(sum_expected.pop_front());
                end
                n_sums++;
            end
            if (hold_left > 0)
                out_ready <= 1'b0;
            else
                out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    initial
    begin
        acc_total = POS_ZERO;
        acc_comp = POS_ZERO;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_left = 0;
        n_words = 0;
        n_sums = 0;
        n_lists = 0;
        n_errors = 0;
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // no list mark after reset, then signed zeros and extremes
        push_word(ONE, 1'b0);
        push_word(NEG_ZERO, 1'b1);
        push_word(NEG_ZERO, 1'b0);
        push_word(NEG_ZERO, 1'b1);
        push_word(POS_ZERO, 1'b0);
        push_word(MAX_FINITE, 1'b1);
        push_word(MAX_FINITE, 1'b0);
        push_word(MIN_SUBNORM, 1'b1);
        push_word(MIN_SUBNORM | NEG_ZERO, 1'b0);
        push_word(64'h000F_FFFF_FFFF_FFFF, 1'b0);
        push_word(PLUS_INF, 1'b1);
        push_word(ONE, 1'b0);
        push_word(MINUS_INF, 1'b0);
        push_word(ONE, 1'b0);
        push_word(64'h7FF0_0000_0000_0001, 1'b1);
        push_word(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        push_word(MINUS_INF, 1'b1);
        // big plus many ones: the compensation must recover the lost bits
        push_word(BIG_2P53, 1'b1);
        for (int i = 0; i < 6; i++)
            push_word(ONE, 1'b0);
        push_word(BIG_2P53 | NEG_ZERO, 1'b0);
        wait_drained();

        push_random(380);
        wait_drained();

        send_idle_pct = 81;
        push_random(370);
        wait_drained();

        send_idle_pct = 0;
        recv_stall_pct = 81;
        push_random(370);
        wait_drained();

        send_idle_pct = 24;
        recv_stall_pct = 24;
        push_random(370);
        wait_drained();

        // long receiver hold-off while words keep coming
        send_idle_pct = 0;
        recv_stall_pct = 10;
        @(negedge clk);
        hold_left = 300;
        push_random(380);
        wait_drained();

        repeat (10) @(negedge clk);
        $display("covered %0d words in %0d lists, %0d sums checked", n_words, n_lists, n_sums);
        $display("phases: free flow, sparse input, stalled output, mixed, long hold-off");
        if (n_errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("timeout");
        $display("testbench: errors");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/krs_pkg.sv
src/kahan_running_sum_core.sv
tb/testbench.sv
